// ===== design/rbs_pkg.sv =====
// Shared constants and types for the ray/box slab intersection unit.
// No dependencies; every other design file imports this package.
package rbs_pkg;

    // Fixed-point format of corners, origins, directions and results.
    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    // Six quotient lanes: lower corner x/y/z, then upper corner x/y/z.
    localparam int LANES     = 6;
    localparam int AXES      = 3;
    // Magnitude of corner minus origin needs 33 bits.
    localparam int NUM_W     = WORD_W + 1;
    // Width of the scaled dividend and of the full quotient.
    localparam int DIV_W     = NUM_W + FRAC_BITS;
    localparam int IDX_W     = 3;

    localparam logic [IDX_W-1:0] REG_MIN_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_MIN_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_MIN_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_MAX_X = 3'd3;
    localparam logic [IDX_W-1:0] REG_MAX_Y = 3'd4;
    localparam logic [IDX_W-1:0] REG_MAX_Z = 3'd5;

    localparam logic signed [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // Per-lane sideband that travels with a division through the pipeline.
    typedef struct packed {
        logic [WORD_W-1:0] den_mag;   // |dir|
        logic              neg;       // quotient sign
        logic              den_zero;  // dir is zero
        logic              num_pos;   // numerator greater than zero
        logic              num_neg;   // numerator less than zero
    } lane_ctl_t;

endpackage

// ===== design/rbs_front.sv =====
// Input stage: forms corner minus origin per lane and splits numerator and
// divisor into magnitudes and signs. Depends on rbs_pkg.
module rbs_front (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         en,
    input  logic                                         in_valid,
    input  logic [rbs_pkg::AXES-1:0][rbs_pkg::WORD_W-1:0] origin,
    input  logic [rbs_pkg::AXES-1:0][rbs_pkg::WORD_W-1:0] dir,
    input  logic [rbs_pkg::LANES-1:0][rbs_pkg::WORD_W-1:0] corner,
    output logic                                         out_valid,
    output logic [rbs_pkg::LANES-1:0][rbs_pkg::NUM_W-1:0] num_mag,
    output rbs_pkg::lane_ctl_t [rbs_pkg::LANES-1:0]       ctl
);
    import rbs_pkg::*;

    logic                               valid_reg;
    logic [LANES-1:0][NUM_W-1:0]        num_mag_reg;
    lane_ctl_t [LANES-1:0]              ctl_reg;
    logic [LANES-1:0][NUM_W-1:0]        num_mag_next;
    lane_ctl_t [LANES-1:0]              ctl_next;

    // Exact 33-bit difference and magnitudes for each lane.
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic signed [NUM_W-1:0]  diff;
        logic signed [WORD_W-1:0] d;
        assign diff = $signed({corner[l][WORD_W-1], corner[l]})
                    - $signed({origin[l % AXES][WORD_W-1], origin[l % AXES]});
        assign d    = $signed(dir[l % AXES]);
        always_comb
        begin
            num_mag_next[l]          = diff[NUM_W-1] ? NUM_W'(-diff) : NUM_W'(diff);
            ctl_next[l].den_mag      = d[WORD_W-1] ? WORD_W'(-d) : WORD_W'(d);
            ctl_next[l].neg          = diff[NUM_W-1] ^ d[WORD_W-1];
            ctl_next[l].den_zero     = (d == '0);
            ctl_next[l].num_pos      = !diff[NUM_W-1] && (diff != '0);
            ctl_next[l].num_neg      = diff[NUM_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_mag_reg <= num_mag_next;
            ctl_reg     <= ctl_next;
        end
    end

    assign out_valid = valid_reg;
    assign num_mag   = num_mag_reg;
    assign ctl       = ctl_reg;

endmodule

// ===== design/rbs_div.sv =====
// Six-lane pipelined restoring divider, one quotient bit per stage.
// Depends on rbs_pkg.
module rbs_div (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          en,
    input  logic                                          in_valid,
    input  logic [rbs_pkg::LANES-1:0][rbs_pkg::NUM_W-1:0] num_mag,
    input  rbs_pkg::lane_ctl_t [rbs_pkg::LANES-1:0]        in_ctl,
    output logic                                          out_valid,
    output logic [rbs_pkg::LANES-1:0][rbs_pkg::DIV_W-1:0] quot,
    output rbs_pkg::lane_ctl_t [rbs_pkg::LANES-1:0]        out_ctl
);
    import rbs_pkg::*;

    // Stage 0 is the input; stage s+1 is registered from stage s.
    logic                                valid_reg [0:DIV_W];
    logic [LANES-1:0][WORD_W-1:0]        rem_reg   [0:DIV_W];
    logic [LANES-1:0][DIV_W-1:0]         dq_reg    [0:DIV_W];
    lane_ctl_t [LANES-1:0]               ctl_reg   [0:DIV_W];

    assign valid_reg[0] = in_valid;
    assign ctl_reg[0]   = in_ctl;
    for (genvar l = 0; l < LANES; l++) begin : g_init
        assign rem_reg[0][l] = '0;
        assign dq_reg[0][l]  = {num_mag[l], {FRAC_BITS{1'b0}}};
    end

    for (genvar s = 0; s < DIV_W; s++) begin : g_step
        logic [LANES-1:0][WORD_W-1:0] rem_next;
        logic [LANES-1:0][DIV_W-1:0]  dq_next;

        // One trial subtract per lane.
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [WORD_W:0]   trial;
            logic [WORD_W+1:0] diff;
            logic              ge;
            assign trial = {rem_reg[s][l], dq_reg[s][l][DIV_W-1]};
            assign diff  = {1'b0, trial} - {2'b00, ctl_reg[s][l].den_mag};
            assign ge    = !diff[WORD_W+1];
            assign rem_next[l] = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
            assign dq_next[l]  = {dq_reg[s][l][DIV_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s+1] <= valid_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= rem_next;
                dq_reg[s+1]  <= dq_next;
                ctl_reg[s+1] <= ctl_reg[s];
            end
        end
    end

    assign out_valid = valid_reg[DIV_W];
    assign quot      = dq_reg[DIV_W];
    assign out_ctl   = ctl_reg[DIV_W];

`ifndef ASSERT_OFF
    // The final remainder stays below a nonzero divisor in the first and last lanes.
    a_rem_x: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ctl[0].den_zero) |-> (rem_reg[DIV_W][0] < out_ctl[0].den_mag))
        else $error("divider remainder not below divisor");
    a_rem_z: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ctl[LANES-1].den_zero)
            |-> (rem_reg[DIV_W][LANES-1] < out_ctl[LANES-1].den_mag))
        else $error("divider remainder not below divisor");
`endif

endmodule

// ===== design/rbs_reduce.sv =====
// Back end: saturates quotients, forms near/far per axis, entry and exit,
// then the saturated difference and hit flag. Depends on rbs_pkg.
module rbs_reduce (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          en,
    input  logic                                          in_valid,
    input  logic [rbs_pkg::LANES-1:0][rbs_pkg::DIV_W-1:0] quot,
    input  rbs_pkg::lane_ctl_t [rbs_pkg::LANES-1:0]        ctl,
    output logic                                          out_valid,
    output logic [rbs_pkg::WORD_W-1:0]                    enter_minus_exit,
    output logic                                          hit
);
    import rbs_pkg::*;

    logic                                 sat_valid_reg, nf_valid_reg, ee_valid_reg, out_valid_reg;
    logic signed [LANES-1:0][WORD_W-1:0]  q_reg, q_next;
    logic signed [AXES-1:0][WORD_W-1:0]   near_reg, far_reg, near_next, far_next;
    logic signed [WORD_W-1:0]             enter_reg, exit_reg, enter_next, exit_next;
    logic signed [WORD_W-1:0]             eme_reg, eme_next;
    logic                                 hit_reg, hit_next;
    logic signed [WORD_W:0]               ediff;

    // Saturate each quotient to 32 bits; zero divisor goes by numerator sign.
    for (genvar l = 0; l < LANES; l++) begin : g_sat
        logic big_pos, big_neg;
        assign big_pos = |quot[l][DIV_W-1:WORD_W-1];
        assign big_neg = (|quot[l][DIV_W-1:WORD_W])
                       || (quot[l][WORD_W-1] && (|quot[l][WORD_W-2:0]));
        always_comb
        begin
            if (ctl[l].den_zero)
            begin
                q_next[l] = ctl[l].num_pos ? SAT_MAX : (ctl[l].num_neg ? SAT_MIN : '0);
            end
            else if (ctl[l].neg)
            begin
                q_next[l] = big_neg ? SAT_MIN : -quot[l][WORD_W-1:0];
            end
            else
            begin
                q_next[l] = big_pos ? SAT_MAX : quot[l][WORD_W-1:0];
            end
        end
    end

    // Near and far per axis; elements of a packed array select as unsigned.
    for (genvar a = 0; a < AXES; a++) begin : g_nf
        assign near_next[a] = ($signed(q_reg[a]) < $signed(q_reg[a+AXES]))
                            ? q_reg[a] : q_reg[a+AXES];
        assign far_next[a]  = ($signed(q_reg[a]) < $signed(q_reg[a+AXES]))
                            ? q_reg[a+AXES] : q_reg[a];
    end

    // Entry is the largest of zero and the near values; exit the smallest far.
    always_comb
    begin
        enter_next = '0;
        if ($signed(near_reg[0]) > enter_next) enter_next = near_reg[0];
        if ($signed(near_reg[1]) > enter_next) enter_next = near_reg[1];
        if ($signed(near_reg[2]) > enter_next) enter_next = near_reg[2];
        exit_next = far_reg[0];
        if ($signed(far_reg[1]) < exit_next) exit_next = far_reg[1];
        if ($signed(far_reg[2]) < exit_next) exit_next = far_reg[2];
    end

    // Exact difference, then saturation.
    always_comb
    begin
        ediff = {enter_reg[WORD_W-1], enter_reg} - {exit_reg[WORD_W-1], exit_reg};
        if (ediff > $signed({SAT_MAX[WORD_W-1], SAT_MAX}))
        begin
            eme_next = SAT_MAX;
        end
        else if (ediff < $signed({SAT_MIN[WORD_W-1], SAT_MIN}))
        begin
            eme_next = SAT_MIN;
        end
        else
        begin
            eme_next = ediff[WORD_W-1:0];
        end
        hit_next = (enter_reg <= exit_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_valid_reg <= 1'b0;
            nf_valid_reg  <= 1'b0;
            ee_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sat_valid_reg <= in_valid;
            nf_valid_reg  <= sat_valid_reg;
            ee_valid_reg  <= nf_valid_reg;
            out_valid_reg <= ee_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg     <= q_next;
            near_reg  <= near_next;
            far_reg   <= far_next;
            enter_reg <= enter_next;
            exit_reg  <= exit_next;
            eme_reg   <= eme_next;
            hit_reg   <= hit_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign enter_minus_exit = eme_reg;
    assign hit              = hit_reg;

`ifndef ASSERT_OFF
    // The near value of an axis never exceeds its far value.
    a_near_far: assert property (@(posedge clk) disable iff (!rst_n)
        nf_valid_reg |-> (($signed(near_reg[0]) <= $signed(far_reg[0]))
                          && ($signed(near_reg[1]) <= $signed(far_reg[1]))
                          && ($signed(near_reg[2]) <= $signed(far_reg[2]))))
        else $error("near value above far value");
    // A hit goes with a difference that is not positive.
    a_hit_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (hit_reg == (eme_reg <= 0)))
        else $error("hit flag disagrees with entry minus exit");
`endif

endmodule

// ===== design/ray_box_slab_intersect_unit.sv =====
// Ray against axis-aligned box slab test, signed Q16.16.
// Top level; instantiates rbs_front, rbs_div and rbs_reduce; uses rbs_pkg.
//
// Usage:
//   The box is written through the configuration port (cfg_we, cfg_index,
//   cfg_data): indexes 0..2 are the lower corner x/y/z, 3..5 the upper
//   corner; other indexes are ignored. Write the box only while idle.
//   Each input word on s_axis carries one ray; each output word on m_axis
//   carries enter minus exit (saturated) in tdata and the hit flag in tuser.
//   The pipeline has one input stage, one stage per quotient bit in the
//   six-lane divider, then four stages for saturation, near/far,
//   entry/exit and the final difference. Throughput is one word per
//   cycle while the receiver takes words.
//   When the receiver stalls with a word waiting, the whole pipeline holds
//   and s_axis_tready drops; no word is lost or repeated.
//   Reset clears all valid bits and the box registers to zero.
module ray_box_slab_intersect_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each)
    input  logic [191:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // enter_minus_exit
    output logic [31:0]  m_axis_tdata,
    // hit
    output logic         m_axis_tuser
);
    import rbs_pkg::*;

    logic [LANES-1:0][WORD_W-1:0]  box_reg;
    logic [AXES-1:0][WORD_W-1:0]   origin, dir;
    logic                          en;
    logic                          fr_valid, dv_valid;
    logic [LANES-1:0][NUM_W-1:0]   num_mag;
    lane_ctl_t [LANES-1:0]         fr_ctl, dv_ctl;
    logic [LANES-1:0][DIV_W-1:0]   quot;

    // Box registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_X: box_reg[0] <= cfg_data;
                REG_MIN_Y: box_reg[1] <= cfg_data;
                REG_MIN_Z: box_reg[2] <= cfg_data;
                REG_MAX_X: box_reg[3] <= cfg_data;
                REG_MAX_Y: box_reg[4] <= cfg_data;
                REG_MAX_Z: box_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack the input word.
    for (genvar a = 0; a < AXES; a++) begin : g_unpack
        assign origin[a] = s_axis_tdata[a*WORD_W +: WORD_W];
        assign dir[a]    = s_axis_tdata[(a+AXES)*WORD_W +: WORD_W];
    end

    // The pipeline advances unless a finished word is waiting.
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    rbs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .origin    (origin),
        .dir       (dir),
        .corner    (box_reg),
        .out_valid (fr_valid),
        .num_mag   (num_mag),
        .ctl       (fr_ctl)
    );

    rbs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .num_mag   (num_mag),
        .in_ctl    (fr_ctl),
        .out_valid (dv_valid),
        .quot      (quot),
        .out_ctl   (dv_ctl)
    );

    rbs_reduce u_reduce (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .in_valid         (dv_valid),
        .quot             (quot),
        .ctl              (dv_ctl),
        .out_valid        (m_axis_tvalid),
        .enter_minus_exit (m_axis_tdata),
        .hit              (m_axis_tuser)
    );

`ifndef ASSERT_OFF
    // A waiting output word stays put until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output word changed while stalled");
`endif

endmodule

// ===== sim/ray_box_slab_intersect_unit_checker.sv =====
// Checker for the ray/box slab intersection unit: watches the config port and
// both streams, predicts each result and compares it. Uses rbs_pkg.
`timescale 1ns / 100ps

module ray_box_slab_intersect_unit_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [31:0]  m_axis_tdata,
    input  logic         m_axis_tuser,
    output int           fail_count,
    output int           pending
);
    import rbs_pkg::*;

    typedef struct {
        logic signed [31:0] span;
        logic               hit;
    } slab_result_t;

    logic signed [31:0] box_lo [AXES];
    logic signed [31:0] box_hi [AXES];
    slab_result_t       expected_hits [$];

    // Scaled quotient with saturation and the zero-divisor rule.
    function automatic longint slab_quotient(longint num, longint den);
        longint q;
        if (den == 0)
            return (num > 0) ? 64'sd2147483647 : (num < 0) ? -64'sd2147483648 : 0;
        q = (num * (64'sd1 <<< FRAC_BITS)) / den;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q;
    endfunction

    function automatic slab_result_t predict_slab(logic [191:0] ray);
        slab_result_t r;
        longint entry, leave, a, b, org, dir, d;
        entry = 0;
        leave = 0;
        for (int ax = 0; ax < AXES; ax++)
        begin
            org = longint'($signed(ray[32*ax +: 32]));
            dir = longint'($signed(ray[32*(ax+3) +: 32]));
            a = slab_quotient(longint'(box_lo[ax]) - org, dir);
            b = slab_quotient(longint'(box_hi[ax]) - org, dir);
            if (a > b)
            begin
                d = a; a = b; b = d;
            end
            if (a > entry) entry = a;
            if (ax == 0 || b < leave) leave = b;
        end
        d = entry - leave;
        if (d > 64'sd2147483647) d = 64'sd2147483647;
        if (d < -64'sd2147483648) d = -64'sd2147483648;
        r.span = d[31:0];
        r.hit = (entry <= leave);
        return r;
    endfunction

    // Track register writes and accepted words at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        slab_result_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                box_lo[i] = 0;
                box_hi[i] = 0;
            end
            fail_count = 0;
            expected_hits.delete();
            pending = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_hits.size() == 0)
                begin
                    $error("unexpected output word %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    e = expected_hits.pop_front();
                    if (m_axis_tdata !== e.span)
                    begin
                        $error("enter_minus_exit expected %h actual %h", e.span, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tuser !== e.hit)
                    begin
                        $error("hit expected %b actual %b", e.hit, m_axis_tuser);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_hits.push_back(predict_slab(s_axis_tdata));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MIN_X: box_lo[0] = cfg_data;
                    REG_MIN_Y: box_lo[1] = cfg_data;
                    REG_MIN_Z: box_lo[2] = cfg_data;
                    REG_MAX_X: box_hi[0] = cfg_data;
                    REG_MAX_Y: box_hi[1] = cfg_data;
                    REG_MAX_Z: box_hi[2] = cfg_data;
                    default: ;
                endcase
            end
            pending = expected_hits.size();
        end
    end

endmodule

// ===== sim/ray_box_slab_intersect_unit_tb.sv =====
// Testbench top for the ray/box slab intersection unit: drives boxes and rays
// under varied flow control. Depends on rbs_pkg, the unit and the checker module.
`timescale 1ns / 100ps

module ray_box_slab_intersect_unit_tb;
    import rbs_pkg::*;

    localparam int LAT = DIV_W + 5;

    logic         clk = 0;
    logic         rst_n = 0;
    logic         cfg_we = 0;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [31:0]  m_axis_tdata;
    logic         m_axis_tuser;
    int           fail_count;
    int           pending;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    bit           hold_off = 0;

    always #4 clk = ~clk;

    ray_box_slab_intersect_unit u_dut (.*);

    ray_box_slab_intersect_unit_checker u_chk (.*);

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(negedge clk)
        m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

    initial
    begin
        #5ms;
        $display("ray_box_slab_intersect_unit test failed");
        $finish;
    end

    // Coordinates biased to small magnitudes, zero and extremes, with some full-range words.
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3, 4: return $urandom;
            default: return $signed($urandom_range(20 << 16)) - (10 << 16);
        endcase
    endfunction

    // The word stays offered after acceptance; idle cycles drop tvalid.
    task automatic send_ray(logic [191:0] ray);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= ray;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // The write enable stays high across back-to-back writes.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    task automatic drain_pipe();
        s_axis_tvalid <= 0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (LAT + 4) @(negedge clk);
    endtask

    task automatic load_box(logic [31:0] v [6]);
        drain_pipe();
        for (int i = 0; i < 6; i++)
            write_reg(i[2:0], v[i]);
        // An out-of-range index must be ignored.
        write_reg(3'd6, $urandom);
        write_reg(3'd7, $urandom);
        cfg_we <= 0;
    endtask

    function automatic logic [191:0] rand_ray();
        logic [191:0] r;
        for (int i = 0; i < 6; i++)
            r[32*i +: 32] = rand_coord();
        if ($urandom_range(3) == 0)
            r[32*(3 + $urandom_range(2)) +: 32] = 0;
        return r;
    endfunction

    initial
    begin
        logic [31:0] bx [6];
        logic [191:0] r;
        repeat (3) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // Directed: unit box, then full-range box.
        bx = '{32'hffff_0000, 32'hffff_0000, 32'hffff_0000,
               32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
        load_box(bx);
        send_ray({96'h0, 32'hfffb_0000, 32'hfffb_0000, 32'hfffb_0000});
        send_ray({32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                  32'hfffb_0000, 32'hfffb_0000, 32'hfffb_0000});
        send_ray({32'h0, 32'h0, 32'h0001_0000, 96'h0});
        send_ray({96'h0, 96'h0});
        send_ray({32'h1, 32'h1, 32'h1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        send_ray({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                  32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff});
        send_ray({32'h0, 32'h0, 32'h0, 32'h7fff_ffff, 32'h0, 32'h8000_0000});
        bx = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
        load_box(bx);
        send_ray({32'h1, 32'hffff_ffff, 32'h1, 32'h7fff_ffff, 32'h8000_0000, 32'h0});
        send_ray({96'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0});
        send_ray({32'h7fff_ffff, 32'h8000_0000, 32'h0, 96'h0});

        // Random phases with different flow control and boxes.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                3: begin send_idle_pct = 20; recv_stall_pct = 20; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int i = 0; i < 6; i++)
                bx[i] = rand_coord();
            if (ph == 4)
                bx = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
            load_box(bx);
            if (ph == 0)
            begin
                // Long receiver hold-off so the pipeline fills and stalls.
                fork
                    begin
                        hold_off = 1;
                        repeat (3 * LAT) @(negedge clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int n = 0; n < 150; n++)
            begin
                r = rand_ray();
                send_ray(r);
            end
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain_pipe();
        if (fail_count == 0)
            $display("ray_box_slab_intersect_unit test passed");
        else
            $display("ray_box_slab_intersect_unit test failed");
        $finish;
    end

endmodule
